[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, masked while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

[rtl/ipv6ihf_pkg.sv]
// Types and constants for the IPv6 ingress header filter.
package ipv6ihf_pkg;

  // Fixed header geometry and match values
  localparam int HEADER_BYTES    = 40;
  localparam logic [3:0] IP_VERSION_6 = 4'h6;
  localparam logic [7:0] MCAST_BYTE_0 = 8'hff;
  localparam logic [7:0] MCAST_BYTE_1 = 8'h02;
  localparam logic [1:0] MCAST_BOTH   = 2'b11;
  localparam int FRAME_FIELD_BITS = 17;
  localparam logic [FRAME_FIELD_BITS-1:0] FRAME_FIELD_MAX = 17'h1ffff;

  // Header byte offsets
  localparam int OFS_VERSION   = 0;
  localparam int OFS_FLOW_0    = 1;
  localparam int OFS_FLOW_1    = 2;
  localparam int OFS_FLOW_2    = 3;
  localparam int OFS_LENGTH_0  = 4;
  localparam int OFS_LENGTH_1  = 5;
  localparam int OFS_NEXT_HDR  = 6;
  localparam int OFS_SRC_START = 8;
  localparam int OFS_DST_START = 24;

  // Protocol slots
  localparam int MAX_SLOTS = 4;
  localparam logic [8:0] PROTO_UNUSED = 9'd256;

  // Configuration register map (8-byte stride)
  localparam int ADDR_BITS = 6;
  localparam int DATA_BITS = 64;
  localparam logic [2:0] REG_OWN_HIGH = 3'd0;
  localparam logic [2:0] REG_OWN_LOW  = 3'd1;
  localparam int REG_PROTO_BASE = 2;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT        = 3'd0,
    VERDICT_TOO_SHORT     = 3'd1,
    VERDICT_BAD_VERSION   = 3'd2,
    VERDICT_NOT_FOR_ME    = 3'd3,
    VERDICT_UNKNOWN_PROTO = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  next_protocol;
    logic [15:0] payload_length;
    logic [19:0] flow_id;
    logic [63:0] source_high;
    logic [63:0] source_low;
    logic        to_multicast;
    logic [16:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } own_addr_t;

  typedef struct packed {
    logic advance;
    logic last;
  } parse_ctl_t;

endpackage

[rtl/ipv6_ingress_header_filter.sv]
// IPv6 ingress header filter: takes one frame byte per transaction, starting at the IPv6
// header, and on the byte flagged last returns one verdict (accept, too short, bad
// version, not for this node, unknown next header) with the captured flow label,
// payload length clamped to the frame length, next header, source address, ff02
// multicast flag and saturating frame length. A byte is taken every cycle; a last byte
// passes from the input register through the combinational capture-and-verdict logic
// into the output register. Only a last byte facing a stalled, full output register
// holds the input. Configuration is written over APB at 8-byte spacing; the user must
// write it only while no frame is in flight, as the block itself does not enforce this.
module ipv6_ingress_header_filter #(
  parameter int PROTOCOL_SLOTS = 4,
  parameter int LENGTH_BITS    = 17
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ipv6ihf_pkg::in_item_t              in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ipv6ihf_pkg::out_item_t             out_item,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ipv6ihf_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [ipv6ihf_pkg::DATA_BITS-1:0]  pwdata,
  output logic [ipv6ihf_pkg::DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  logic                           s1_valid_r, s1_valid_nxt;
  ipv6ihf_pkg::in_item_t          s1_item_r;
  logic                           out_valid_r, out_valid_nxt;
  ipv6ihf_pkg::out_item_t         out_item_r;
  logic                           advance;
  logic                           in_take;
  ipv6ihf_pkg::parse_ctl_t        ctl;
  ipv6ihf_pkg::own_addr_t         own;
  logic [PROTOCOL_SLOTS-1:0][8:0] proto_slots;
  ipv6ihf_pkg::out_item_t         result;

  ipv6ihf_regs #(
    .PROTOCOL_SLOTS(PROTOCOL_SLOTS)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .own         (own),
    .proto_slots (proto_slots)
  );

  // A middle byte always moves on; a last byte needs room in the output register
  assign advance  = s1_valid_r &&
                    (!s1_item_r.last_byte || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign ctl.advance = advance;
  assign ctl.last    = s1_item_r.last_byte;

  ipv6ihf_parse #(
    .PROTOCOL_SLOTS(PROTOCOL_SLOTS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .data_byte   (s1_item_r.data_byte),
    .own         (own),
    .proto_slots (proto_slots),
    .result      (result)
  );

  // Input register occupancy
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Output register occupancy: load on a last byte, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && s1_item_r.last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (advance && s1_item_r.last_byte) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/ipv6ihf_regs.sv]
// APB configuration registers: own address and accepted protocol slots.
module ipv6ihf_regs #(
  parameter int PROTOCOL_SLOTS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ipv6ihf_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [ipv6ihf_pkg::DATA_BITS-1:0]   pwdata,
  output logic [ipv6ihf_pkg::DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output ipv6ihf_pkg::own_addr_t              own,
  output logic [PROTOCOL_SLOTS-1:0][8:0]      proto_slots
);

  logic [63:0]                    own_high_r, own_high_nxt;
  logic [63:0]                    own_low_r, own_low_nxt;
  logic [PROTOCOL_SLOTS-1:0][8:0] proto_r, proto_nxt;
  logic                           wr_en;
  logic [2:0]                     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ipv6ihf_pkg::ADDR_BITS-1:3];

  // Decode register writes
  always_comb begin
    own_high_nxt = own_high_r;
    own_low_nxt  = own_low_r;
    proto_nxt    = proto_r;
    if (wr_en) begin
      if (reg_idx == ipv6ihf_pkg::REG_OWN_HIGH) begin
        own_high_nxt = pwdata;
      end
      if (reg_idx == ipv6ihf_pkg::REG_OWN_LOW) begin
        own_low_nxt = pwdata;
      end
      for (int j = 0; j < PROTOCOL_SLOTS; j++) begin
        if (reg_idx == 3'(ipv6ihf_pkg::REG_PROTO_BASE + j)) begin
          proto_nxt[j] = pwdata[8:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_high_r <= '0;
      own_low_r  <= '0;
      for (int j = 0; j < PROTOCOL_SLOTS; j++) begin
        proto_r[j] <= ipv6ihf_pkg::PROTO_UNUSED;
      end
    end else begin
      own_high_r <= own_high_nxt;
      own_low_r  <= own_low_nxt;
      proto_r    <= proto_nxt;
    end
  end

  // Read back; slots beyond the built ones read as unused
  always_comb begin
    prdata = '0;
    case (reg_idx)
      ipv6ihf_pkg::REG_OWN_HIGH: prdata = own_high_r;
      ipv6ihf_pkg::REG_OWN_LOW:  prdata = own_low_r;
      default: begin
        for (int j = 0; j < ipv6ihf_pkg::MAX_SLOTS; j++) begin
          if (reg_idx == 3'(ipv6ihf_pkg::REG_PROTO_BASE + j)) begin
            prdata = 64'(ipv6ihf_pkg::PROTO_UNUSED);
          end
        end
        for (int j = 0; j < PROTOCOL_SLOTS; j++) begin
          if (reg_idx == 3'(ipv6ihf_pkg::REG_PROTO_BASE + j)) begin
            prdata = 64'(proto_r[j]);
          end
        end
      end
    endcase
  end

  assign own.high    = own_high_r;
  assign own.low     = own_low_r;
  assign proto_slots = proto_r;

endmodule

[rtl/ipv6ihf_parse.sv]
// Per-frame header capture, destination match and verdict logic.
module ipv6ihf_parse #(
  parameter int PROTOCOL_SLOTS = 4,
  parameter int LENGTH_BITS    = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ipv6ihf_pkg::parse_ctl_t        ctl,
  input  logic [7:0]                     data_byte,
  input  ipv6ihf_pkg::own_addr_t         own,
  input  logic [PROTOCOL_SLOTS-1:0][8:0] proto_slots,
  output ipv6ihf_pkg::out_item_t         result
);

  localparam int LW = (LENGTH_BITS > ipv6ihf_pkg::FRAME_FIELD_BITS) ?
                      LENGTH_BITS : ipv6ihf_pkg::FRAME_FIELD_BITS;

  logic [LENGTH_BITS-1:0] pos_r, pos_nxt;
  logic [3:0]             version_r, version_nxt;
  logic [19:0]            flow_r, flow_nxt;
  logic [15:0]            length_r, length_nxt;
  logic [7:0]             proto_r, proto_nxt;
  logic [63:0]            src_hi_r, src_hi_nxt;
  logic [63:0]            src_lo_r, src_lo_nxt;
  logic                   mismatch_r, mismatch_nxt;
  logic [1:0]             mcast_r, mcast_nxt;

  // Values after the current byte is captured
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [3:0]             cap_version;
  logic [19:0]            cap_flow;
  logic [15:0]            cap_length;
  logic [7:0]             cap_proto;
  logic [63:0]            cap_src_hi;
  logic [63:0]            cap_src_lo;
  logic                   cap_mismatch;
  logic [1:0]             cap_mcast;

  logic                   in_src;
  logic                   in_dst;
  logic [2:0]             lane;
  logic [63:0]            own_sel;
  logic [7:0]             own_byte;

  logic                   too_short;
  logic                   multi;
  logic                   found;
  logic [15:0]            plen;
  logic [LW-1:0]          flen_w;

  assign in_src  = (pos_r >= LENGTH_BITS'(ipv6ihf_pkg::OFS_SRC_START)) &&
                   (pos_r <  LENGTH_BITS'(ipv6ihf_pkg::OFS_DST_START));
  assign in_dst  = (pos_r >= LENGTH_BITS'(ipv6ihf_pkg::OFS_DST_START)) &&
                   (pos_r <  LENGTH_BITS'(ipv6ihf_pkg::HEADER_BYTES));
  // Byte lane counted from the least significant end of a 64-bit half
  assign lane     = 3'd7 - pos_r[2:0];
  // Offsets 24..31 hold the upper half of the destination
  assign own_sel  = pos_r[3] ? own.high : own.low;
  assign own_byte = own_sel[{lane, 3'b000} +: 8];

  // Capture the current byte into its header field
  always_comb begin
    cap_version  = version_r;
    cap_flow     = flow_r;
    cap_length   = length_r;
    cap_proto    = proto_r;
    cap_src_hi   = src_hi_r;
    cap_src_lo   = src_lo_r;
    cap_mismatch = mismatch_r;
    cap_mcast    = mcast_r;
    if (pos_r == LENGTH_BITS'(ipv6ihf_pkg::OFS_VERSION)) begin
      cap_version = data_byte[7:4];
    end
    if (pos_r == LENGTH_BITS'(ipv6ihf_pkg::OFS_FLOW_0)) begin
      cap_flow[19:16] = data_byte[3:0];
    end
    if (pos_r == LENGTH_BITS'(ipv6ihf_pkg::OFS_FLOW_1)) begin
      cap_flow[15:8] = data_byte;
    end
    if (pos_r == LENGTH_BITS'(ipv6ihf_pkg::OFS_FLOW_2)) begin
      cap_flow[7:0] = data_byte;
    end
    if (pos_r == LENGTH_BITS'(ipv6ihf_pkg::OFS_LENGTH_0)) begin
      cap_length[15:8] = data_byte;
    end
    if (pos_r == LENGTH_BITS'(ipv6ihf_pkg::OFS_LENGTH_1)) begin
      cap_length[7:0] = data_byte;
    end
    if (pos_r == LENGTH_BITS'(ipv6ihf_pkg::OFS_NEXT_HDR)) begin
      cap_proto = data_byte;
    end
    if (in_src) begin
      for (int j = 0; j < 8; j++) begin
        if (lane == 3'(j)) begin
          if (pos_r[4]) begin
            cap_src_lo[8*j +: 8] = data_byte;
          end else begin
            cap_src_hi[8*j +: 8] = data_byte;
          end
        end
      end
    end
    if (in_dst) begin
      if (own_byte != data_byte) begin
        cap_mismatch = 1'b1;
      end
      if (pos_r == LENGTH_BITS'(ipv6ihf_pkg::OFS_DST_START) &&
          data_byte == ipv6ihf_pkg::MCAST_BYTE_0) begin
        cap_mcast[0] = 1'b1;
      end
      if (pos_r == LENGTH_BITS'(ipv6ihf_pkg::OFS_DST_START + 1) &&
          data_byte == ipv6ihf_pkg::MCAST_BYTE_1) begin
        cap_mcast[1] = 1'b1;
      end
    end
  end

  // Saturating byte count including the current byte
  assign cnt_inc = (pos_r != '1) ? pos_r + 1'b1 : pos_r;

  // Advance per-frame state; clear it after the last byte
  always_comb begin
    pos_nxt      = pos_r;
    version_nxt  = version_r;
    flow_nxt     = flow_r;
    length_nxt   = length_r;
    proto_nxt    = proto_r;
    src_hi_nxt   = src_hi_r;
    src_lo_nxt   = src_lo_r;
    mismatch_nxt = mismatch_r;
    mcast_nxt    = mcast_r;
    if (ctl.advance) begin
      if (ctl.last) begin
        pos_nxt      = '0;
        version_nxt  = '0;
        flow_nxt     = '0;
        length_nxt   = '0;
        proto_nxt    = '0;
        src_hi_nxt   = '0;
        src_lo_nxt   = '0;
        mismatch_nxt = 1'b0;
        mcast_nxt    = '0;
      end else begin
        pos_nxt      = cnt_inc;
        version_nxt  = cap_version;
        flow_nxt     = cap_flow;
        length_nxt   = cap_length;
        proto_nxt    = cap_proto;
        src_hi_nxt   = cap_src_hi;
        src_lo_nxt   = cap_src_lo;
        mismatch_nxt = cap_mismatch;
        mcast_nxt    = cap_mcast;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      version_r  <= '0;
      flow_r     <= '0;
      length_r   <= '0;
      proto_r    <= '0;
      src_hi_r   <= '0;
      src_lo_r   <= '0;
      mismatch_r <= 1'b0;
      mcast_r    <= '0;
    end else begin
      pos_r      <= pos_nxt;
      version_r  <= version_nxt;
      flow_r     <= flow_nxt;
      length_r   <= length_nxt;
      proto_r    <= proto_nxt;
      src_hi_r   <= src_hi_nxt;
      src_lo_r   <= src_lo_nxt;
      mismatch_r <= mismatch_nxt;
      mcast_r    <= mcast_nxt;
    end
  end

  // Verdict inputs
  assign too_short = cnt_inc < LENGTH_BITS'(ipv6ihf_pkg::HEADER_BYTES);
  assign multi     = (cap_mcast == ipv6ihf_pkg::MCAST_BOTH);
  assign plen      = (LENGTH_BITS'(cap_length) > cnt_inc) ? cnt_inc[15:0] : cap_length;
  assign flen_w    = LW'(cnt_inc);

  always_comb begin
    found = 1'b0;
    for (int j = 0; j < PROTOCOL_SLOTS; j++) begin
      if (proto_slots[j] == {1'b0, cap_proto}) begin
        found = 1'b1;
      end
    end
  end

  // Build the result item for a last byte
  always_comb begin
    result = '0;
    if (flen_w > LW'(ipv6ihf_pkg::FRAME_FIELD_MAX)) begin
      result.frame_length = ipv6ihf_pkg::FRAME_FIELD_MAX;
    end else begin
      result.frame_length = flen_w[ipv6ihf_pkg::FRAME_FIELD_BITS-1:0];
    end
    if (too_short) begin
      result.verdict = ipv6ihf_pkg::VERDICT_TOO_SHORT;
    end else begin
      if (cap_version != ipv6ihf_pkg::IP_VERSION_6) begin
        result.verdict = ipv6ihf_pkg::VERDICT_BAD_VERSION;
      end else if (cap_mismatch && !multi) begin
        result.verdict = ipv6ihf_pkg::VERDICT_NOT_FOR_ME;
      end else if (!found) begin
        result.verdict = ipv6ihf_pkg::VERDICT_UNKNOWN_PROTO;
      end else begin
        result.verdict = ipv6ihf_pkg::VERDICT_ACCEPT;
      end
      result.next_protocol  = cap_proto;
      result.payload_length = plen;
      result.flow_id        = cap_flow;
      result.source_high    = cap_src_hi;
      result.source_low     = cap_src_lo;
      result.to_multicast   = multi;
    end
  end

endmodule

[rtl/ipv6ihf_checker.sv]
// Port-level assertions for the IPv6 ingress header filter, bound to the top level.
`include "assert_macros.svh"

module ipv6ihf_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input ipv6ihf_pkg::out_item_t out_item
);

  // No result straight out of reset
  `ASSERT_CLK_ALWAYS(a_no_result_after_reset, !rst_n |=> !out_valid, "result after reset")

  // A stalled result holds
  `ASSERT_CLK(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled result changed")

  // Too short exactly when the frame is under one header
  `ASSERT_CLK(a_short_len, out_valid |-> ((out_item.verdict == ipv6ihf_pkg::VERDICT_TOO_SHORT) == (out_item.frame_length < 17'(ipv6ihf_pkg::HEADER_BYTES))), "short verdict and frame length disagree")

  // Payload length never exceeds the frame length
  `ASSERT_CLK(a_plen_clamp, out_valid |-> (17'(out_item.payload_length) <= out_item.frame_length), "payload length not clamped")

endmodule

bind ipv6_ingress_header_filter ipv6ihf_checker u_ipv6ihf_checker (.*);

[verif/ipv6_ingress_header_filter_tb.sv]
// Self-checking testbench for the IPv6 ingress header filter: directed and random frames and a predictor.
module ipv6_ingress_header_filter_tb;

  typedef ipv6ihf_pkg::in_item_t  in_item_t;
  typedef ipv6ihf_pkg::out_item_t out_item_t;

  localparam int PROTOCOL_SLOTS = 4;
  localparam int LENGTH_BITS    = 17;
  localparam int unsigned POSITION_MAX = (1 << LENGTH_BITS) - 1;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_BYTES    = 130;
  localparam int PHASE_FRAMES   = 3;

  // Predicts one verdict per frame and checks results against them in order
  class frame_verdict_checker;
    logic [63:0] own_high, own_low;
    logic [8:0]  proto_slot[ipv6ihf_pkg::MAX_SLOTS];
    int unsigned position;
    logic [3:0]  ver;
    logic [19:0] flow;
    logic [15:0] plen;
    logic [7:0]  nh;
    logic [63:0] src_hi, src_lo;
    bit          dst_miss;
    logic [1:0]  mc_seen;
    out_item_t   verdicts_due[$];
    int          mismatches;
    int          checked;
    int          tally[5];

    function new();
      own_high = '0;
      own_low  = '0;
      foreach (proto_slot[i]) proto_slot[i] = ipv6ihf_pkg::PROTO_UNUSED;
      mismatches = 0;
      checked = 0;
      foreach (tally[i]) tally[i] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      position = 0;
      ver = '0;
      flow = '0;
      plen = '0;
      nh = '0;
      src_hi = '0;
      src_lo = '0;
      dst_miss = 0;
      mc_seen = '0;
    endfunction

    function void set_register(int idx, logic [63:0] value);
      if (idx == ipv6ihf_pkg::REG_OWN_HIGH) own_high = value;
      else if (idx == ipv6ihf_pkg::REG_OWN_LOW) own_low = value;
      else if (idx >= ipv6ihf_pkg::REG_PROTO_BASE &&
               idx < ipv6ihf_pkg::REG_PROTO_BASE + ipv6ihf_pkg::MAX_SLOTS)
        proto_slot[idx - ipv6ihf_pkg::REG_PROTO_BASE] = value[8:0];
    endfunction

    // Capture one accepted byte; on the last byte queue the verdict
    function void take_byte(in_item_t it);
      logic [7:0]  b;
      logic [7:0]  own_byte;
      int unsigned sh;
      int unsigned flen;
      bit          multi;
      bit          found;
      out_item_t   due;
      b = it.data_byte;
      if (position == ipv6ihf_pkg::OFS_VERSION) ver = b[7:4];
      else if (position == ipv6ihf_pkg::OFS_FLOW_0) flow[19:16] = b[3:0];
      else if (position == ipv6ihf_pkg::OFS_FLOW_1) flow[15:8] = b;
      else if (position == ipv6ihf_pkg::OFS_FLOW_2) flow[7:0] = b;
      else if (position == ipv6ihf_pkg::OFS_LENGTH_0) plen[15:8] = b;
      else if (position == ipv6ihf_pkg::OFS_LENGTH_1) plen[7:0] = b;
      else if (position == ipv6ihf_pkg::OFS_NEXT_HDR) nh = b;
      else if (position >= ipv6ihf_pkg::OFS_SRC_START &&
               position < ipv6ihf_pkg::OFS_DST_START) begin
        sh = (7 - (position - ipv6ihf_pkg::OFS_SRC_START) % 8) * 8;
        if (position < ipv6ihf_pkg::OFS_SRC_START + 8) src_hi[sh +: 8] = b;
        else src_lo[sh +: 8] = b;
      end else if (position >= ipv6ihf_pkg::OFS_DST_START &&
                   position < ipv6ihf_pkg::HEADER_BYTES) begin
        sh = (7 - (position - ipv6ihf_pkg::OFS_DST_START) % 8) * 8;
        own_byte = (position < ipv6ihf_pkg::OFS_DST_START + 8) ?
                   own_high[sh +: 8] : own_low[sh +: 8];
        if (own_byte != b) dst_miss = 1;
        if (position == ipv6ihf_pkg::OFS_DST_START && b == ipv6ihf_pkg::MCAST_BYTE_0)
          mc_seen[0] = 1'b1;
        if (position == ipv6ihf_pkg::OFS_DST_START + 1 && b == ipv6ihf_pkg::MCAST_BYTE_1)
          mc_seen[1] = 1'b1;
      end
      // Saturate the length counter
      if (position < POSITION_MAX) position++;
      if (!it.last_byte) return;

      flen  = position;
      multi = (mc_seen == ipv6ihf_pkg::MCAST_BOTH);
      found = 0;
      for (int i = 0; i < PROTOCOL_SLOTS; i++)
        if (proto_slot[i] == {1'b0, nh}) found = 1;
      due = '0;
      due.frame_length = (flen > ipv6ihf_pkg::FRAME_FIELD_MAX) ?
                         ipv6ihf_pkg::FRAME_FIELD_MAX : 17'(flen);
      if (flen < ipv6ihf_pkg::HEADER_BYTES) begin
        due.verdict = ipv6ihf_pkg::VERDICT_TOO_SHORT;
      end else begin
        if (ver != ipv6ihf_pkg::IP_VERSION_6) due.verdict = ipv6ihf_pkg::VERDICT_BAD_VERSION;
        else if (dst_miss && !multi) due.verdict = ipv6ihf_pkg::VERDICT_NOT_FOR_ME;
        else if (found) due.verdict = ipv6ihf_pkg::VERDICT_ACCEPT;
        else due.verdict = ipv6ihf_pkg::VERDICT_UNKNOWN_PROTO;
        due.next_protocol  = nh;
        due.payload_length = (plen > flen) ? 16'(flen) : plen;
        due.flow_id        = flow;
        due.source_high    = src_hi;
        due.source_low     = src_lo;
        due.to_multicast   = multi;
      end
      verdicts_due.insert(verdicts_due.size(), due);
      tally[int'(due.verdict)]++;
      clear_frame();
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH result %0d %s: expected %h actual %h", checked, what, want, got);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) flag(name, want, got);
    endfunction

    // Compare one accepted result with the oldest outstanding verdict
    function void match_verdict(out_item_t got);
      out_item_t want;
      if (verdicts_due.size() == 0) begin
        flag("result with no frame outstanding, verdict", '0, got.verdict);
        return;
      end
      want = verdicts_due.pop_front();
      checked++;
      compare_field("verdict", want.verdict, got.verdict);
      compare_field("next_protocol", want.next_protocol, got.next_protocol);
      compare_field("payload_length", want.payload_length, got.payload_length);
      compare_field("flow_id", want.flow_id, got.flow_id);
      compare_field("source_high", want.source_high, got.source_high);
      compare_field("source_low", want.source_low, got.source_low);
      compare_field("to_multicast", want.to_multicast, got.to_multicast);
      compare_field("frame_length", want.frame_length, got.frame_length);
    endfunction
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [ipv6ihf_pkg::ADDR_BITS-1:0] paddr  = '0;
  logic [ipv6ihf_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [ipv6ihf_pkg::DATA_BITS-1:0] prdata;
  logic        pready;

  frame_verdict_checker book = new();
  logic [7:0]  frame_bytes[$];
  bit          send_idle = 0;
  logic        recv_idle = 1'b0;
  logic        hold_on   = 1'b0;
  int          stall_run = 0;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          frames_sent = 0;
  int          settings_used = 0;

  ipv6_ingress_header_filter #(
    .PROTOCOL_SLOTS(PROTOCOL_SLOTS),
    .LENGTH_BITS(LENGTH_BITS)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d verdicts outstanding",
               cycle_count, book.verdicts_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Check accepted results and drive random stall bursts plus the long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else begin
      if (out_valid && !out_stall) book.match_verdict(out_item);
      if (stall_run > 0) stall_run--;
      else if (recv_idle && $urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 7);
      out_stall <= hold_on || (stall_run > 0);
    end
  end

  // Append one byte to the frame under construction
  function automatic void add_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endfunction

  // Hold the output stalled for a long stretch
  task automatic start_hold();
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
  endtask

  // Two-phase register write; the bus is left idle before the task returns
  task automatic write_register(input int idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ipv6ihf_pkg::ADDR_BITS'(idx * 8);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    book.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] own_hi, own_lo, p0, p1, p2, p3);
    write_register(ipv6ihf_pkg::REG_OWN_HIGH, own_hi);
    write_register(ipv6ihf_pkg::REG_OWN_LOW, own_lo);
    write_register(ipv6ihf_pkg::REG_PROTO_BASE + 0, p0);
    write_register(ipv6ihf_pkg::REG_PROTO_BASE + 1, p1);
    write_register(ipv6ihf_pkg::REG_PROTO_BASE + 2, p2);
    write_register(ipv6ihf_pkg::REG_PROTO_BASE + 3, p3);
    settings_used++;
  endtask

  // Offer one byte and wait for its transaction
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    if (send_idle && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.take_byte(it);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int n;
    n = frame_bytes.size();
    for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
    frames_sent++;
  endtask

  // Drop valid, wait for every verdict, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Fill frame_bytes with a 40-byte header and a random payload
  function automatic void build_header(input logic [3:0] ver, input logic [19:0] flow,
                                       input logic [15:0] plen, input logic [7:0] nh,
                                       input logic [63:0] src_hi, src_lo, dst_hi, dst_lo,
                                       input int payload);
    frame_bytes.delete();
    add_byte({ver, 4'($urandom)});
    add_byte({4'($urandom), flow[19:16]});
    add_byte(flow[15:8]);
    add_byte(flow[7:0]);
    add_byte(plen[15:8]);
    add_byte(plen[7:0]);
    add_byte(nh);
    add_byte(8'($urandom));
    for (int i = 7; i >= 0; i--) add_byte(src_hi[i*8 +: 8]);
    for (int i = 7; i >= 0; i--) add_byte(src_lo[i*8 +: 8]);
    for (int i = 7; i >= 0; i--) add_byte(dst_hi[i*8 +: 8]);
    for (int i = 7; i >= 0; i--) add_byte(dst_lo[i*8 +: 8]);
    repeat (payload) add_byte(8'($urandom));
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed frames, with foreign, multicast, damaged and short ones mixed in
  task automatic send_random_frame();
    int          kind;
    int          payload;
    int          cut;
    int          pick;
    logic [3:0]  ver;
    logic [8:0]  slot;
    logic [7:0]  nh;
    logic [15:0] plen;
    logic [63:0] dst_hi, dst_lo;
    kind    = $urandom_range(0, 99);
    payload = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
    slot    = book.proto_slot[$urandom_range(0, ipv6ihf_pkg::MAX_SLOTS - 1)];
    nh      = (slot < ipv6ihf_pkg::PROTO_UNUSED && $urandom_range(0, 3) != 0) ?
              slot[7:0] : 8'($urandom);
    case ($urandom_range(0, 3))
      0: plen = 16'(payload);
      1: plen = 16'($urandom);
      2: plen = 16'h0000;
      default: plen = 16'hffff;
    endcase
    dst_hi = book.own_high;
    dst_lo = book.own_low;
    if (kind >= 45 && kind < 60) begin
      dst_hi = rand64();
      dst_lo = rand64();
      case ($urandom_range(0, 3))
        0: dst_hi[63:48] = 16'hff03;
        1: dst_hi[63:48] = 16'hfe02;
        default: dst_hi[63:48] = {ipv6ihf_pkg::MCAST_BYTE_0, ipv6ihf_pkg::MCAST_BYTE_1};
      endcase
    end
    ver = (kind >= 70 && kind < 78) ? 4'($urandom) : ipv6ihf_pkg::IP_VERSION_6;
    build_header(ver, 20'($urandom), plen, nh, rand64(), rand64(), dst_hi, dst_lo, payload);
    // Flip one destination bit
    if (kind >= 60 && kind < 70) begin
      pick = ipv6ihf_pkg::OFS_DST_START + $urandom_range(0, 15);
      frame_bytes[pick] = frame_bytes[pick] ^ 8'(1 << $urandom_range(0, 7));
    end
    // Truncate inside the header
    if (kind >= 78 && kind < 90) begin
      cut = $urandom_range(1, ipv6ihf_pkg::HEADER_BYTES - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    if (kind >= 90) foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom);
    send_frame();
  endtask

  task automatic run_phase(input logic [63:0] own_hi, own_lo, p0, p1, p2, p3,
                           input bit pressure, input bit calm);
    int first_byte;
    int first_frame;
    configure(own_hi, own_lo, p0, p1, p2, p3);
    first_byte  = bytes_sent;
    first_frame = frames_sent;
    if (pressure) begin
      // Pile up short frames against a stalled output
      start_hold();
      repeat (40) begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
        send_frame();
      end
    end
    while (bytes_sent - first_byte < PHASE_BYTES || frames_sent - first_frame < PHASE_FRAMES)
    begin
      if (calm) begin
        send_idle = 0;
        recv_idle <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        send_idle = ($urandom_range(0, 4) != 0);
        recv_idle <= ($urandom_range(0, 4) != 0);
      end
      send_random_frame();
    end
    settle();
  endtask

  initial begin
    logic [63:0] own_hi;
    logic [63:0] own_lo;
    out_item_t   lost;
    own_hi = 64'h2001_0db8_0000_0001;
    own_lo = 64'h0000_0000_0000_0001;

    // Synchronous reset
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames
    configure(own_hi, own_lo, 64'd6, 64'd17, 64'd58, 64'hbeef_0000_0000_0100);
    send_idle = 1;
    recv_idle <= 1'b1;
    // single-byte frame
    frame_bytes.delete();
    add_byte(8'hff);
    send_frame();
    // header one byte short
    build_header(ipv6ihf_pkg::IP_VERSION_6, 20'h12345, 16'd8, 8'd6, rand64(), rand64(),
                 own_hi, own_lo, 0);
    void'(frame_bytes.pop_back());
    send_frame();
    // bare header, accepted
    build_header(ipv6ihf_pkg::IP_VERSION_6, 20'h0, 16'h0, 8'd6, 64'h0, 64'h0,
                 own_hi, own_lo, 0);
    send_frame();
    // all-ones fields, payload length clamps to the frame length
    build_header(ipv6ihf_pkg::IP_VERSION_6, 20'hfffff, 16'hffff, 8'd17, '1, '1,
                 own_hi, own_lo, 5);
    send_frame();
    // bad version outranks a foreign destination; also with the own destination
    build_header(4'h4, 20'h1, 16'd3, 8'd6, rand64(), rand64(), rand64(), rand64(), 3);
    send_frame();
    build_header(4'hf, 20'h2, 16'd0, 8'd6, rand64(), rand64(), own_hi, own_lo, 0);
    send_frame();
    // foreign unicast destination
    build_header(ipv6ihf_pkg::IP_VERSION_6, 20'h3, 16'd2, 8'd6, rand64(), rand64(),
                 own_hi, ~own_lo, 2);
    send_frame();
    // link-local multicast to a registered protocol
    build_header(ipv6ihf_pkg::IP_VERSION_6, 20'h4, 16'd8, 8'd58, rand64(), rand64(),
                 64'hff02_0000_0000_0000, 64'h1, 8);
    send_frame();
    // hop-by-hop next header is not walked
    build_header(ipv6ihf_pkg::IP_VERSION_6, 20'h5, 16'd8, 8'd0, rand64(), rand64(),
                 64'hff02_0000_0000_0000, 64'h1, 8);
    send_frame();
    // near-multicast prefixes
    build_header(ipv6ihf_pkg::IP_VERSION_6, 20'h6, 16'd0, 8'd58, rand64(), rand64(),
                 64'hff03_0000_0000_0000, 64'h1, 0);
    send_frame();
    build_header(ipv6ihf_pkg::IP_VERSION_6, 20'h7, 16'd0, 8'd58, rand64(), rand64(),
                 64'hfe02_0000_0000_0000, 64'h1, 0);
    send_frame();
    // unregistered next header
    build_header(ipv6ihf_pkg::IP_VERSION_6, 20'h8, 16'd0, 8'hff, rand64(), rand64(),
                 own_hi, own_lo, 0);
    send_frame();
    // slot holding the unused marker with junk upper bits matches nothing
    build_header(ipv6ihf_pkg::IP_VERSION_6, 20'h9, 16'd0, 8'h00, rand64(), rand64(),
                 own_hi, own_lo, 0);
    send_frame();
    // trailing bytes are counted only
    build_header(ipv6ihf_pkg::IP_VERSION_6, 20'ha, 16'd20, 8'd17, rand64(), rand64(),
                 own_hi, own_lo, 60);
    send_frame();
    send_idle = 0;
    settle();

    // Random phases across register settings
    run_phase('0, '0, 64'd0, 64'd255, 64'h100, '1, 1, 0);
    run_phase('1, '1, rand64() & ~64'h100, rand64(), rand64(), rand64(), 0, 0);
    run_phase({ipv6ihf_pkg::MCAST_BYTE_0, ipv6ihf_pkg::MCAST_BYTE_1, 48'($urandom)}, rand64(),
              64'd58, 64'd6, rand64(), rand64() & ~64'h100, 0, 0);
    run_phase(rand64(), rand64(), rand64() & ~64'h100, rand64() & ~64'h100,
              rand64(), rand64(), 0, 0);
    run_phase(rand64(), rand64(), 64'd6, 64'd17, 64'd43, 64'd60, 0, 1);

    // Anything still outstanding never arrived
    while (book.verdicts_due.size() != 0) begin
      lost = book.verdicts_due.pop_front();
      book.flag("missing result, verdict", lost.verdict, 'x);
    end

    $display("Covered %0d bytes in %0d frames under %0d register settings and a %0d-cycle hold.",
             bytes_sent, frames_sent, settings_used, HOLD_CYCLES);
    $display("Checked %0d verdicts: accept %0d, too short %0d, bad version %0d, ",
             book.checked, book.tally[ipv6ihf_pkg::VERDICT_ACCEPT],
             book.tally[ipv6ihf_pkg::VERDICT_TOO_SHORT],
             book.tally[ipv6ihf_pkg::VERDICT_BAD_VERSION],
             "not for me %0d, unknown next header %0d; %0d mismatches.",
             book.tally[ipv6ihf_pkg::VERDICT_NOT_FOR_ME],
             book.tally[ipv6ihf_pkg::VERDICT_UNKNOWN_PROTO], book.mismatches);
    if (book.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ipv6ihf_pkg.sv
rtl/ipv6ihf_regs.sv
rtl/ipv6ihf_parse.sv
rtl/ipv6_ingress_header_filter.sv
rtl/ipv6ihf_checker.sv
verif/ipv6_ingress_header_filter_tb.sv
